### sv/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// lpsc_pkg: shared types and constants
// Widths, start-code bytes, register map and the result bundle that passes
// from the conversion core to the output stage.
// ----------------------------------------------------------------------------
package lpsc_pkg;

    // Counter width for sample and output positions
    localparam int CNT_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int HDR_W       = 32;
    // Width used for the exact end-of-unit compares
    localparam int EXT_W       = HDR_W + 2;
    localparam int EXT_PAD_W   = EXT_W - CNT_W;

    // APB register map
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_SEL_OUT_CAP = 1'b0;   // paddr[2] of out_capacity

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(262144);

    // Start code 00 00 00 01
    localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;
    localparam logic [2:0]        SC_LEN       = 3'd4;

    // Results caused by one input byte, in delivery order:
    // start code (4 bytes) or one payload byte, then the end record
    typedef struct packed {
        logic              start_code;
        logic              payload;
        logic [BYTE_W-1:0] pay_byte;
        logic              end_rec;
        logic [CNT_W-1:0]  total;
    } bundle_t;

endpackage

### sv/lpsc_core.sv
// ----------------------------------------------------------------------------
// lpsc_core: per-byte conversion step
// Holds the sample state (header gather, positions, payload count, phase)
// and works out the results of one accepted byte in a single pass.
// ----------------------------------------------------------------------------
module lpsc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [lpsc_pkg::BYTE_W-1:0]     data_byte,
    input  logic [lpsc_pkg::CNT_W-1:0]      sample_bytes,
    input  logic                            first_of_sample,
    input  logic [lpsc_pkg::CNT_W-1:0]      cap,
    output lpsc_pkg::bundle_t               bundle
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [lpsc_pkg::HDR_W-1:0]    header_value_reg, header_value_next;
    logic [1:0]                    header_count_reg, header_count_next;
    logic [lpsc_pkg::CNT_W-1:0]    in_position_reg, in_position_next;
    logic [lpsc_pkg::CNT_W-1:0]    out_position_reg, out_position_next;
    logic [lpsc_pkg::HDR_W-1:0]    payload_left_reg, payload_left_next;

    // state as seen by this byte, after a possible new-sample clear
    phase_t                        ph_cur;
    logic [lpsc_pkg::HDR_W-1:0]    hv_cur;
    logic [1:0]                    hc_cur;
    logic [lpsc_pkg::CNT_W-1:0]    ip_cur;
    logic [lpsc_pkg::CNT_W-1:0]    op_cur;
    logic [lpsc_pkg::HDR_W-1:0]    pl_cur;

    logic [lpsc_pkg::HDR_W-1:0]    hv_shift;
    logic [lpsc_pkg::CNT_W-1:0]    ip_inc;
    logic [lpsc_pkg::EXT_W-1:0]    len_ext;
    logic [lpsc_pkg::EXT_W-1:0]    in_end;
    logic [lpsc_pkg::EXT_W-1:0]    out_end;
    logic [lpsc_pkg::EXT_W-1:0]    size_ext;
    logic [lpsc_pkg::EXT_W-1:0]    cap_ext;
    logic                          unit_bad;
    logic                          past_end;
    logic [lpsc_pkg::HDR_W-1:0]    pl_dec;

    // Clear on first byte of a sample
    always_comb
    begin
        if (first_of_sample)
        begin
            ph_cur = PH_HEADER;
            hv_cur = '0;
            hc_cur = '0;
            ip_cur = '0;
            op_cur = '0;
            pl_cur = '0;
        end
        else
        begin
            ph_cur = phase_reg;
            hv_cur = header_value_reg;
            hc_cur = header_count_reg;
            ip_cur = in_position_reg;
            op_cur = out_position_reg;
            pl_cur = payload_left_reg;
        end
    end

    // Unit bounds: payload must fit the sample and the output capacity
    assign hv_shift = {hv_cur[lpsc_pkg::HDR_W-lpsc_pkg::BYTE_W-1:0], data_byte};
    assign ip_inc   = ip_cur + lpsc_pkg::CNT_W'(1);
    assign len_ext  = lpsc_pkg::EXT_W'(hv_shift);
    assign size_ext = {{lpsc_pkg::EXT_PAD_W{1'b0}}, sample_bytes};
    assign cap_ext  = {{lpsc_pkg::EXT_PAD_W{1'b0}}, cap};
    assign in_end   = {{lpsc_pkg::EXT_PAD_W{1'b0}}, ip_inc} + len_ext;
    assign out_end  = {{lpsc_pkg::EXT_PAD_W{1'b0}}, op_cur}
                      + lpsc_pkg::EXT_W'(lpsc_pkg::SC_LEN) + len_ext;
    assign unit_bad = (in_end > size_ext) || (out_end > cap_ext);
    assign past_end = (ip_cur >= sample_bytes);
    assign pl_dec   = pl_cur - lpsc_pkg::HDR_W'(1);

    // Step logic
    always_comb
    begin
        phase_next        = ph_cur;
        header_value_next = hv_cur;
        header_count_next = hc_cur;
        in_position_next  = ip_cur;
        out_position_next = op_cur;
        payload_left_next = pl_cur;
        bundle            = '0;
        bundle.pay_byte   = data_byte;

        if (!past_end)
        begin
            in_position_next = ip_inc;
            case (ph_cur)
                PH_HEADER:
                begin
                    if (hc_cur == 2'd3)
                    begin
                        header_count_next = '0;
                        header_value_next = '0;
                        if (unit_bad)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else
                        begin
                            bundle.start_code = 1'b1;
                            out_position_next = op_cur
                                                + lpsc_pkg::CNT_W'(lpsc_pkg::SC_LEN);
                            payload_left_next = hv_shift;
                            phase_next = (hv_shift != '0) ? PH_PAYLOAD : PH_HEADER;
                        end
                    end
                    else
                    begin
                        header_value_next = hv_shift;
                        header_count_next = hc_cur + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    bundle.payload    = 1'b1;
                    out_position_next = op_cur + lpsc_pkg::CNT_W'(1);
                    payload_left_next = pl_dec;
                    if (pl_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_STOPPED;
                end
            endcase

            // End record on the last byte of the sample
            if (ip_inc == sample_bytes)
            begin
                bundle.end_rec = 1'b1;
                bundle.total   = out_position_next;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_value_reg <= '0;
            header_count_reg <= '0;
            in_position_reg  <= '0;
            out_position_reg <= '0;
            payload_left_reg <= '0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            header_value_reg <= header_value_next;
            header_count_reg <= header_count_next;
            in_position_reg  <= in_position_next;
            out_position_reg <= out_position_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

### sv/lpsc_out.sv
// ----------------------------------------------------------------------------
// lpsc_out: result register and serializer
// Holds the results of one byte and hands them out one transfer at a time:
// start-code bytes or the payload byte first, then the end record.
// ----------------------------------------------------------------------------
module lpsc_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  lpsc_pkg::bundle_t               bundle_in,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lpsc_pkg::BYTE_W-1:0]     out_byte,
    output logic                            is_end,
    output logic [lpsc_pkg::CNT_W-1:0]      total_bytes
);

    logic [2:0]                    sc_left_reg, sc_left_next;
    logic                          pay_reg, pay_next;
    logic                          end_reg, end_next;
    logic [lpsc_pkg::BYTE_W-1:0]   pay_byte_reg;
    logic [lpsc_pkg::CNT_W-1:0]    total_reg;

    logic                          has_sc;
    logic [2:0]                    remaining;
    logic                          pop;

    // Pending results and the front of the queue
    assign has_sc    = (sc_left_reg != '0);
    assign remaining = sc_left_reg + {2'b00, pay_reg} + {2'b00, end_reg};
    assign out_valid = (remaining != '0);
    assign pop       = out_valid && out_ready;
    assign free      = !out_valid || (out_ready && (remaining == 3'd1));

    assign is_end      = !has_sc && !pay_reg && end_reg;
    assign total_bytes = is_end ? total_reg : '0;

    always_comb
    begin
        if (has_sc)
        begin
            out_byte = (sc_left_reg == 3'd1) ? lpsc_pkg::SC_LAST_BYTE
                                             : lpsc_pkg::SC_ZERO_BYTE;
        end
        else if (pay_reg)
        begin
            out_byte = pay_byte_reg;
        end
        else
        begin
            out_byte = '0;
        end
    end

    // Load a new bundle or retire the front result
    always_comb
    begin
        sc_left_next = sc_left_reg;
        pay_next     = pay_reg;
        end_next     = end_reg;
        if (load)
        begin
            sc_left_next = bundle_in.start_code ? lpsc_pkg::SC_LEN : 3'd0;
            pay_next     = bundle_in.payload;
            end_next     = bundle_in.end_rec;
        end
        else if (pop)
        begin
            if (has_sc)
            begin
                sc_left_next = sc_left_reg - 3'd1;
            end
            else if (pay_reg)
            begin
                pay_next = 1'b0;
            end
            else
            begin
                end_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_left_reg <= '0;
            pay_reg     <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            sc_left_reg <= sc_left_next;
            pay_reg     <= pay_next;
            end_reg     <= end_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pay_byte_reg <= bundle_in.pay_byte;
            total_reg    <= bundle_in.total;
        end
    end

endmodule

### sv/length_prefix_to_start_code.sv
// ----------------------------------------------------------------------------
// length_prefix_to_start_code: length-prefixed to start-code video conversion
// Replaces each 4-byte big-endian unit length with 00 00 00 01, passes the
// payload through and closes every sample with an end record.
//
//   Channel   Direction  Signals                                  Transfer
//   in        sink       data_byte, sample_bytes, first_of_sample valid & ready
//   out       source     out_byte, is_end, total_bytes            valid & ready
//   apb       slave      psel, penable, pwrite, paddr, pwdata     access phase
//
// One input byte per cycle when the output is taken every cycle; a byte whose
// results need more than one output transfer holds the input until its last
// transfer is taken (longest on a header's last byte with an end record),
// set by the single result register. Results of a byte appear in the cycle
// after its transfer. Reset gives the state of a fresh sample and out_capacity
// 262144. A stalled output keeps in_ready low while any result is pending.
// ----------------------------------------------------------------------------
module length_prefix_to_start_code (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lpsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lpsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input stream
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lpsc_pkg::BYTE_W-1:0]         data_byte,
    input  logic [lpsc_pkg::CNT_W-1:0]          sample_bytes,
    input  logic                                first_of_sample,
    // output stream
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lpsc_pkg::BYTE_W-1:0]         out_byte,
    output logic                                is_end,
    output logic [lpsc_pkg::CNT_W-1:0]          total_bytes
);

    logic [lpsc_pkg::CNT_W-1:0]    cap_reg;
    logic                          cap_sel;
    logic                          take;
    logic                          out_free;
    lpsc_pkg::bundle_t             bundle;

    // Configuration register
    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == lpsc_pkg::REG_SEL_OUT_CAP);
    assign prdata  = cap_sel ? lpsc_pkg::APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lpsc_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[lpsc_pkg::CNT_W-1:0];
        end
    end

    // Input transfer
    assign in_ready = out_free;
    assign take     = in_valid && in_ready;

    lpsc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .data_byte       (data_byte),
        .sample_bytes    (sample_bytes),
        .first_of_sample (first_of_sample),
        .cap             (cap_reg),
        .bundle          (bundle)
    );

    lpsc_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .bundle_in   (bundle),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_end      (is_end),
        .total_bytes (total_bytes)
    );

endmodule

### sv/lpsc_checker.sv
// ----------------------------------------------------------------------------
// lpsc_checker: port-level checks
// Watches the top-level ports of the converter; attached by bind.
// ----------------------------------------------------------------------------
module lpsc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lpsc_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [lpsc_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [lpsc_pkg::BYTE_W-1:0]         out_byte,
    input  logic                                is_end,
    input  logic [lpsc_pkg::CNT_W-1:0]          total_bytes
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
                                    && $stable(is_end) && $stable(total_bytes))
        else $error("output transfer changed while stalled");

    // End record carries a zero byte
    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> out_byte == '0)
        else $error("end record with nonzero byte");

    // Stream bytes carry no total
    a_data_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> total_bytes == '0)
        else $error("stream byte with nonzero total");

    // Written capacity reads back
    a_cap_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> paddr[2] || prdata[lpsc_pkg::CNT_W-1:0]
                        == $past(pwdata[lpsc_pkg::CNT_W-1:0]))
        else $error("capacity register readback mismatch");

    // Register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind length_prefix_to_start_code lpsc_checker u_lpsc_checker (.*);

### sim/tb_length_prefix_to_start_code.sv
// ----------------------------------------------------------------------------
// tb_length_prefix_to_start_code: self-checking bench for the start-code converter
// Feeds length-prefixed samples byte by byte, predicts the start-code stream
// and end records in a scoreboard and compares every output transfer in order.
// Covers truncated headers, overrunning units, capacity stops, bytes past the
// end, zero-length samples and several out_capacity settings under random
// backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_length_prefix_to_start_code;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lpsc_pkg::BYTE_W-1:0] byte_t;
    typedef logic [lpsc_pkg::CNT_W-1:0]  cnt_t;
    typedef logic [lpsc_pkg::HDR_W-1:0]  hdr_t;
    typedef logic [lpsc_pkg::EXT_W-1:0]  ext_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_STOPPED
    } conv_phase_t;

    typedef struct packed {
        byte_t out_data;
        logic  end_rec;
        cnt_t  total;
    } stream_result_t;

    localparam logic [lpsc_pkg::APB_ADDR_W-1:0] ADDR_OUT_CAP =
        {lpsc_pkg::REG_SEL_OUT_CAP, 2'b00};
    localparam int  DRAIN_CYCLES = 8;
    localparam int  LONG_HOLD    = 300;
    localparam int  MAX_REPORTS  = 40;
    localparam time TIMEOUT_NS   = 2_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: conversion predictor plus queue of pending output transfers
    // ------------------------------------------------------------------------
    class start_code_scoreboard;
        stream_result_t expected_q[$];
        cnt_t        capacity  = lpsc_pkg::CAP_RESET;
        hdr_t        hdr_val   = '0;
        logic [2:0]  hdr_cnt   = '0;
        cnt_t        in_pos    = '0;
        cnt_t        out_pos   = '0;
        hdr_t        pay_left  = '0;
        conv_phase_t ph        = PH_HEADER;
        int          errors        = 0;
        int          results_seen  = 0;
        int          end_records   = 0;
        int          stopped_units = 0;

        function void push_result(byte_t b, logic end_rec, cnt_t total);
            stream_result_t r;
            r.out_data = b;
            r.end_rec  = end_rec;
            r.total    = total;
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the results of one accepted byte; returns 1 if it was taken
        function bit convert_byte(byte_t b, cnt_t sample_len, logic first);
            ext_t end_in;
            ext_t end_out;
            if (first)
            begin
                hdr_val  = '0;
                hdr_cnt  = '0;
                in_pos   = '0;
                out_pos  = '0;
                pay_left = '0;
                ph       = PH_HEADER;
            end
            // past the end of the sample: ignored
            if (in_pos >= sample_len)
                return 0;
            in_pos++;
            case (ph)
                PH_HEADER:
                begin
                    hdr_val = {hdr_val[lpsc_pkg::HDR_W-lpsc_pkg::BYTE_W-1:0], b};
                    hdr_cnt++;
                    if (hdr_cnt == lpsc_pkg::SC_LEN)
                    begin
                        hdr_cnt = '0;
                        end_in  = ext_t'(in_pos) + ext_t'(hdr_val);
                        end_out = ext_t'(out_pos) + ext_t'(lpsc_pkg::SC_LEN)
                                  + ext_t'(hdr_val);
                        if (end_in > ext_t'(sample_len) || end_out > ext_t'(capacity))
                        begin
                            ph = PH_STOPPED;
                            stopped_units++;
                        end
                        else
                        begin
                            push_result(lpsc_pkg::SC_ZERO_BYTE, 1'b0, '0);
                            push_result(lpsc_pkg::SC_ZERO_BYTE, 1'b0, '0);
                            push_result(lpsc_pkg::SC_ZERO_BYTE, 1'b0, '0);
                            push_result(lpsc_pkg::SC_LAST_BYTE, 1'b0, '0);
                            out_pos  = out_pos + cnt_t'(lpsc_pkg::SC_LEN);
                            pay_left = hdr_val;
                            ph       = (hdr_val != '0) ? PH_PAYLOAD : PH_HEADER;
                        end
                        hdr_val = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    push_result(b, 1'b0, '0);
                    out_pos++;
                    pay_left--;
                    if (pay_left == '0)
                        ph = PH_HEADER;
                end
                default: ;
            endcase
            // end record closes the sample on its last byte
            if (in_pos == sample_len)
                push_result('0, 1'b1, out_pos);
            return 1;
        endfunction

        function void report(string what, longint unsigned exp_v,
                             longint unsigned got_v);
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, exp_v, got_v);
            errors++;
        endfunction

        // Compare one output transfer with the oldest expectation
        function void compare_output(byte_t got_byte, logic got_end, cnt_t got_total);
            stream_result_t exp_r;
            results_seen++;
            if (got_end)
                end_records++;
            if (expected_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display({"%0t: unexpected output, expected none, ",
                              "actual byte %02h end %0b total %0d"},
                             $time, got_byte, got_end, got_total);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got_byte !== exp_r.out_data)
                report("out_byte", exp_r.out_data, got_byte);
            if (got_end !== exp_r.end_rec)
                report("is_end", exp_r.end_rec, got_end);
            if (got_total !== exp_r.total)
                report("total_bytes", exp_r.total, got_total);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                            clk             = 1'b0;
    logic                            rst_n           = 1'b0;
    logic                            psel            = 1'b0;
    logic                            penable         = 1'b0;
    logic                            pwrite          = 1'b0;
    logic [lpsc_pkg::APB_ADDR_W-1:0] paddr           = '0;
    logic [lpsc_pkg::APB_DATA_W-1:0] pwdata          = '0;
    logic [lpsc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid        = 1'b0;
    logic                            in_ready;
    byte_t                           data_byte       = '0;
    cnt_t                            sample_bytes    = '0;
    logic                            first_of_sample = 1'b0;
    logic                            out_valid;
    logic                            out_ready       = 1'b0;
    byte_t                           out_byte;
    logic                            is_end;
    cnt_t                            total_bytes;

    start_code_scoreboard sb = new;

    byte_t sample_q[$];
    bit    tx_idle      = 1'b1;
    bit    rx_idle      = 1'b1;
    bit    hold_req     = 1'b0;
    int    sent_items   = 0;
    int    taken_items  = 0;
    int    cap_settings = 0;

    length_prefix_to_start_code i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .sample_bytes    (sample_bytes),
        .first_of_sample (first_of_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .is_end          (is_end),
        .total_bytes     (total_bytes)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard limit on run time
    initial
    begin
        #(TIMEOUT_NS);
        $display("length_prefix_to_start_code regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: check transfers, random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.compare_output(out_byte, is_end, total_bytes);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && rx_idle && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // One input transfer, then an optional idle burst
    task automatic send_byte(input byte_t b, input cnt_t sample_len, input logic first);
        in_valid        <= 1'b1;
        data_byte       <= b;
        sample_bytes    <= sample_len;
        first_of_sample <= first;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
        if (sb.convert_byte(b, sample_len, first))
            taken_items++;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_sample(input cnt_t sample_len, input logic first_mark);
        for (int i = 0; i < sample_q.size(); i++)
            send_byte(sample_q[i], sample_len, (i == 0) ? first_mark : 1'b0);
        sample_q.delete();
    endtask

    // Big-endian unit length
    task automatic add_header(input hdr_t len);
        for (int k = 3; k >= 0; k--)
            sample_q.push_back(len[8*k +: 8]);
    endtask

    task automatic add_unit(input int unsigned len);
        add_header(hdr_t'(len));
        repeat (len) sample_q.push_back(byte_t'($urandom));
    endtask

    function automatic int unsigned pick_unit_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        else if (r < 8)
            return $urandom_range(1, 6);
        return $urandom_range(7, 24);
    endfunction

    // Stop offering input, wait for all results, then let the core settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of out_capacity, then a read-back in the next access
    task automatic set_capacity(input cnt_t cap);
        logic [lpsc_pkg::APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OUT_CAP;
        pwdata  <= lpsc_pkg::APB_DATA_W'(cap);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.capacity = cap;
        cap_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[lpsc_pkg::CNT_W-1:0] !== cap)
            sb.report("out_capacity read-back", cap, rd[lpsc_pkg::CNT_W-1:0]);
    endtask

    // Mostly well-formed samples, with broken and noisy ones mixed in
    task automatic random_sample();
        int   kind;
        int   tail;
        cnt_t sample_len;
        logic first_mark;
        kind       = $urandom_range(0, 19);
        first_mark = 1'b1;
        sample_q.delete();
        repeat ($urandom_range(1, 3)) add_unit(pick_unit_len());
        sample_len = cnt_t'(sample_q.size());
        if (kind == 14 || kind == 15)
        begin
            // sample ends inside a header
            repeat ($urandom_range(1, 3)) sample_q.push_back(byte_t'($urandom));
            sample_len = cnt_t'(sample_q.size());
        end
        else if (kind == 16 || kind == 17)
        begin
            // unit runs past the sample: random length or one byte too long
            tail = $urandom_range(0, 3);
            add_header((kind == 16) ? hdr_t'($urandom) : hdr_t'(tail + 1));
            repeat (tail) sample_q.push_back(byte_t'($urandom));
            sample_len = cnt_t'(sample_q.size());
        end
        else if (kind == 18)
        begin
            // noise: random bytes, random length, random first mark
            sample_q.delete();
            repeat ($urandom_range(1, 12)) sample_q.push_back(byte_t'($urandom));
            case ($urandom_range(0, 2))
                0:       sample_len = '0;
                1:       sample_len = cnt_t'($urandom_range(1, 16));
                default: sample_len = cnt_t'($urandom);
            endcase
            first_mark = 1'($urandom_range(0, 1));
        end
        else if (kind == 19)
        begin
            // trailing bytes past the end of the sample
            repeat ($urandom_range(1, 3)) sample_q.push_back(byte_t'($urandom));
        end
        send_sample(sample_len, first_mark);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int   target;
        cnt_t cap;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no first mark after reset; zero-length unit then a one-byte unit
        add_header(32'h0000_0000);
        add_header(32'h0000_0001);
        sample_q.push_back(8'hFF);
        send_sample(cnt_t'(sample_q.size()), 1'b0);

        // header cut short, then a byte past the end
        sample_q.push_back(8'h00);
        sample_q.push_back(8'h00);
        sample_q.push_back(8'hA5);
        send_sample(cnt_t'(2), 1'b1);

        // unit of maximum length overruns the sample
        add_header(32'hFFFF_FFFF);
        send_sample(cnt_t'(4), 1'b1);

        // zero sample length
        sample_q.push_back(8'h3C);
        send_sample('0, 1'b1);

        // widest sample length, left open
        add_header(32'h0000_0000);
        send_sample({lpsc_pkg::CNT_W{1'b1}}, 1'b1);

        // capacity exactly met by the first unit, exceeded by the second
        wait_idle();
        set_capacity(cnt_t'(4));
        add_header(32'h0000_0000);
        add_header(32'h0000_0000);
        send_sample(cnt_t'(8), 1'b1);

        // random phases over a range of capacities
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            case (p)
                0:       cap = {lpsc_pkg::CNT_W{1'b1}};
                1:       cap = cnt_t'($urandom_range(8, 40));
                2:       cap = '0;
                3:       cap = cnt_t'($urandom);
                4:       cap = cnt_t'($urandom_range(12, 60));
                default: cap = {lpsc_pkg::CNT_W{1'b1}};
            endcase
            if (p == 3)
                hold_req = 1'b1;
            set_capacity(cap);
            if (p == 3)
            begin
                // long output hold-off while the input keeps streaming
                tx_idle = 1'b0;
                repeat (5) add_unit($urandom_range(4, 8));
                send_sample(cnt_t'(sample_q.size()), 1'b1);
                tx_idle = 1'b1;
            end
            if (p == 5)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            target = taken_items + ((p == 2) ? 8 : 20);
            while (taken_items < target)
                random_sample();
        end

        wait_idle();
        $display("Sent %0d bytes (%0d taken) over %0d capacity settings",
                 sent_items, taken_items, cap_settings);
        $display("Checked %0d output transfers: %0d end records, %0d stopped units",
                 sb.results_seen, sb.end_records, sb.stopped_units);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("length_prefix_to_start_code regression: pass");
        else
            $display("length_prefix_to_start_code regression: fail");
        $finish;
    end

endmodule
